/* src/fltd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fltd_pkg
// Shared types and constants of the fixed-length code table decoder.
// ----------------------------------------------------------------------------
package fltd_pkg;

	localparam int CODE_BITS_DEF    = 7;
	localparam int SYMBOL_BYTES_DEF = 4;
	localparam int MAX_RESULTS      = 8;
	localparam int RES_CNT_W        = 4;
	localparam int END_CODE_W       = 7;
	localparam logic [END_CODE_W-1:0] END_CODE_RESET = 7'h7F;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = 1;
	localparam int QCNT_W      = 2;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_BYTE  = 2'd1;
	localparam logic [1:0] OP_END   = 2'd2;

	typedef enum logic [1:0] {
		K_WRITE = 2'd0,
		K_BYTE  = 2'd1,
		K_END   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_DATA  = 2'd0,
		ST_END   = 2'd1,
		ST_NOEND = 2'd2
	} status_t;

	typedef struct packed {
		kind_t       kind;
		logic [6:0]  entry_index;
		logic [7:0]  entry_byte0;
		logic [7:0]  entry_byte1;
		logic [7:0]  entry_byte2;
		logic [7:0]  entry_byte3;
		logic [2:0]  entry_length;
		logic [7:0]  in_byte;
	} cmd_t;

	typedef struct packed {
		logic        push;
		logic        close;
		logic [7:0]  data;
		status_t     status;
	} res_ctl_t;

endpackage

/* src/fltd_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fltd_front
// Accepts input words, drops unused operations and queues the rest.
// ----------------------------------------------------------------------------
module fltd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        operation,
	input  logic [6:0]        entry_index,
	input  logic [7:0]        entry_byte0,
	input  logic [7:0]        entry_byte1,
	input  logic [7:0]        entry_byte2,
	input  logic [7:0]        entry_byte3,
	input  logic [2:0]        entry_length,
	input  logic [7:0]        in_byte,
	input  logic              run,
	output logic              q_valid,
	output fltd_pkg::cmd_t    q_cmd,
	input  logic              q_pop
);
	import fltd_pkg::*;

	cmd_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              push;
	cmd_t              cmd_in;

	assign in_ready = run && (cnt_q != QCNT_W'(QUEUE_DEPTH));

	always_comb begin
		cmd_in.kind         = K_WRITE;
		cmd_in.entry_index  = entry_index;
		cmd_in.entry_byte0  = entry_byte0;
		cmd_in.entry_byte1  = entry_byte1;
		cmd_in.entry_byte2  = entry_byte2;
		cmd_in.entry_byte3  = entry_byte3;
		cmd_in.entry_length = entry_length;
		cmd_in.in_byte      = in_byte;
		push                = in_valid && in_ready;
		unique case (operation)
			OP_WRITE: cmd_in.kind = K_WRITE;
			OP_BYTE:  cmd_in.kind = K_BYTE;
			OP_END:   cmd_in.kind = K_END;
			default:  push = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= cmd_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + QPTR_W'(1);
			end
			if (q_pop) begin
				rd_q <= rd_q + QPTR_W'(1);
			end
			cnt_q <= cnt_q + QCNT_W'(push) - QCNT_W'(q_pop);
		end
	end

	assign q_valid = (cnt_q != '0);
	assign q_cmd   = slot_q[rd_q];

endmodule

/* src/fltd_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fltd_back
// Holds the symbol table and the bit buffer and turns queued words into
// results, one symbol byte per cycle while the output stage can take it.
// ----------------------------------------------------------------------------
module fltd_back #(
	parameter int CODE_BITS    = fltd_pkg::CODE_BITS_DEF,
	parameter int SYMBOL_BYTES = fltd_pkg::SYMBOL_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [fltd_pkg::END_CODE_W-1:0] end_code,
	input  logic                            q_valid,
	input  fltd_pkg::cmd_t                  q_cmd,
	output logic                            q_pop,
	output logic                            run,
	input  logic                            res_ok,
	output fltd_pkg::res_ctl_t              res_ctl
);
	import fltd_pkg::*;

	localparam int DEPTH = 1 << CODE_BITS;
	localparam int SW    = CODE_BITS + 7;
	localparam int CNW   = $clog2(CODE_BITS + 8);
	localparam int KW    = $clog2(SYMBOL_BYTES + 1);
	localparam int SYMW  = SYMBOL_BYTES * 8;
	localparam int MW    = KW + SYMW;
	localparam int CW    = (CODE_BITS > END_CODE_W) ? CODE_BITS : END_CODE_W;

	typedef enum logic [5:0] {
		S_CLEAR   = 6'b000001,
		S_IDLE    = 6'b000010,
		S_EXTRACT = 6'b000100,
		S_EMIT    = 6'b001000,
		S_ENDRES  = 6'b010000,
		S_CLOSE   = 6'b100000
	} state_t;

	state_t                 st_q, st_d;
	logic [CODE_BITS-1:0]   clr_q, clr_d;
	logic [SW-1:0]          store_q, store_d;
	logic [CNW-1:0]         cnt_q, cnt_d;
	logic                   done_q, done_d;
	logic [RES_CNT_W-1:0]   n_q, n_d;
	logic [KW-1:0]          k_q, k_d;

	logic [MW-1:0]          mem [DEPTH];
	logic [MW-1:0]          rd_q;
	logic                   we;
	logic [CODE_BITS-1:0]   waddr;
	logic [MW-1:0]          wdata;
	logic                   re;

	logic [CODE_BITS-1:0]   cmd_idx;
	logic [KW-1:0]          cmd_len;
	logic [SYMW-1:0]        cmd_sym;
	logic [CNW-1:0]         rem;
	logic [CODE_BITS-1:0]   code;
	logic                   code_is_end;
	logic [SW-1:0]          keep_mask;
	logic [KW-1:0]          len_rd;
	logic [SYMW-1:0]        sym_rd;
	logic [7:0]             byte_k;
	logic                   full;

	always_comb begin
		cmd_idx = CODE_BITS'(q_cmd.entry_index);
		cmd_sym = SYMW'({q_cmd.entry_byte3, q_cmd.entry_byte2,
			q_cmd.entry_byte1, q_cmd.entry_byte0});
		if (int'(q_cmd.entry_length) > SYMBOL_BYTES) begin
			cmd_len = KW'(SYMBOL_BYTES);
		end else begin
			cmd_len = KW'(q_cmd.entry_length);
		end
	end

	assign rem         = cnt_q - CNW'(CODE_BITS);
	assign code        = CODE_BITS'(store_q >> rem);
	assign code_is_end = (CW'(code) == CW'(end_code));
	assign keep_mask   = ~({SW{1'b1}} << rem);
	assign len_rd      = rd_q[MW-1:SYMW];
	assign sym_rd      = rd_q[SYMW-1:0];
	assign byte_k      = 8'(sym_rd >> {k_q, 3'b000});
	assign full        = (n_q >= RES_CNT_W'(MAX_RESULTS));
	assign run         = (st_q != S_CLEAR);

	always_comb begin
		st_d           = st_q;
		clr_d          = clr_q;
		store_d        = store_q;
		cnt_d          = cnt_q;
		done_d         = done_q;
		n_d            = n_q;
		k_d            = k_q;
		q_pop          = 1'b0;
		we             = 1'b0;
		waddr          = cmd_idx;
		wdata          = {cmd_len, cmd_sym};
		re             = 1'b0;
		res_ctl.push   = 1'b0;
		res_ctl.close  = 1'b0;
		res_ctl.data   = '0;
		res_ctl.status = ST_DATA;
		unique case (st_q)
			S_CLEAR: begin
				we    = 1'b1;
				waddr = clr_q;
				wdata = '0;
				clr_d = clr_q + CODE_BITS'(1);
				if (&clr_q) begin
					st_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					unique case (q_cmd.kind)
						K_WRITE: we = 1'b1;
						K_BYTE: begin
							if (!done_q) begin
								store_d = SW'({store_q, q_cmd.in_byte});
								cnt_d   = cnt_q + CNW'(8);
								n_d     = '0;
								st_d    = S_EXTRACT;
							end
						end
						K_END: begin
							store_d = '0;
							cnt_d   = '0;
							done_d  = 1'b0;
							if (!done_q) begin
								st_d = S_ENDRES;
							end
						end
						default: ;
					endcase
				end
			end
			S_EXTRACT: begin
				if (cnt_q >= CNW'(CODE_BITS)) begin
					if (code_is_end) begin
						if (full || res_ok) begin
							if (!full) begin
								res_ctl.push   = 1'b1;
								res_ctl.status = ST_END;
								n_d            = n_q + RES_CNT_W'(1);
							end
							done_d  = 1'b1;
							store_d = '0;
							cnt_d   = '0;
							st_d    = S_CLOSE;
						end
					end else begin
						re      = 1'b1;
						cnt_d   = rem;
						store_d = store_q & keep_mask;
						k_d     = '0;
						st_d    = S_EMIT;
					end
				end else begin
					st_d = S_CLOSE;
				end
			end
			S_EMIT: begin
				if (k_q < len_rd) begin
					if (full) begin
						k_d = k_q + KW'(1);
					end else if (res_ok) begin
						res_ctl.push = 1'b1;
						res_ctl.data = byte_k;
						n_d          = n_q + RES_CNT_W'(1);
						k_d          = k_q + KW'(1);
					end
				end else begin
					st_d = S_EXTRACT;
				end
			end
			S_ENDRES: begin
				if (res_ok) begin
					res_ctl.push   = 1'b1;
					res_ctl.status = ST_NOEND;
					st_d           = S_CLOSE;
				end
			end
			S_CLOSE: begin
				if (res_ok) begin
					res_ctl.close = 1'b1;
					st_d          = S_IDLE;
				end
			end
			default: st_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem[code];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= S_CLEAR;
			clr_q   <= '0;
			store_q <= '0;
			cnt_q   <= '0;
			done_q  <= 1'b0;
			n_q     <= '0;
			k_q     <= '0;
		end else begin
			st_q    <= st_d;
			clr_q   <= clr_d;
			store_q <= store_d;
			cnt_q   <= cnt_d;
			done_q  <= done_d;
			n_q     <= n_d;
			k_q     <= k_d;
		end
	end

`ifndef NO_ASSERTIONS
	a_push_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_ctl.push |-> res_ok)
		else $error("result pushed while the output stage cannot take it");

	a_push_close: assert property (@(posedge clk) disable iff (!arst_n)
		!(res_ctl.push && res_ctl.close))
		else $error("result push and word close in the same cycle");

	a_done_empty: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (cnt_q == '0))
		else $error("bits held after the end code was seen");

	a_result_cap: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= RES_CNT_W'(MAX_RESULTS))
		else $error("result count per word above its limit");
`endif

endmodule

/* src/fltd_out.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fltd_out
// Holds back the newest result until the next one or the close of its word
// arrives, so that the last flag is known, then drives the output register.
// ----------------------------------------------------------------------------
module fltd_out (
	input  logic               clk,
	input  logic               arst_n,
	input  fltd_pkg::res_ctl_t res_ctl,
	output logic               res_ok,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         out_byte,
	output logic [1:0]         status,
	output logic               last
);
	import fltd_pkg::*;

	logic       hold_v_q;
	logic [7:0] hold_data_q;
	status_t    hold_status_q;
	logic       out_v_q;
	logic [7:0] out_data_q;
	status_t    out_status_q;
	logic       out_last_q;
	logic       out_free;
	logic       move;

	assign out_free = !out_v_q || out_ready;
	assign res_ok   = !hold_v_q || out_free;
	assign move     = hold_v_q && (res_ctl.push || res_ctl.close);

	always_ff @(posedge clk) begin
		if (res_ctl.push) begin
			hold_data_q   <= res_ctl.data;
			hold_status_q <= res_ctl.status;
		end
		if (move) begin
			out_data_q   <= hold_data_q;
			out_status_q <= hold_status_q;
			out_last_q   <= res_ctl.close;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (move) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
			if (res_ctl.push) begin
				hold_v_q <= 1'b1;
			end else if (res_ctl.close) begin
				hold_v_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_v_q;
	assign out_byte  = out_data_q;
	assign status    = out_status_q;
	assign last      = out_last_q;

endmodule

/* src/fixed_length_code_table_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_length_code_table_decoder
// Decodes a byte stream of packed fixed-length codes through a symbol table
// that is loaded by input words.
// ----------------------------------------------------------------------------
//  channel  handshake              payload
//  in       in_valid / in_ready    operation, entry_*, in_byte
//  out      out_valid / out_ready  out_byte, status, last
//  cfg      cfg_valid / cfg_ready  end_code
//
//  After reset the table is cleared entry by entry; in_ready is low meanwhile,
//  configuration words are taken at any time. A stream byte is added to the
//  bit buffer; each whole code in it is then looked up and its symbol bytes are
//  sent one by one. After the end code, stream bytes are dropped until an end
//  of input. Output stalls hold the decoder.
//  A two-word queue lets input words enter while results wait on the output.
// ----------------------------------------------------------------------------
module fixed_length_code_table_decoder #(
	parameter int CODE_BITS    = fltd_pkg::CODE_BITS_DEF,
	parameter int SYMBOL_BYTES = fltd_pkg::SYMBOL_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [1:0]                      operation,
	input  logic [6:0]                      entry_index,
	input  logic [7:0]                      entry_byte0,
	input  logic [7:0]                      entry_byte1,
	input  logic [7:0]                      entry_byte2,
	input  logic [7:0]                      entry_byte3,
	input  logic [2:0]                      entry_length,
	input  logic [7:0]                      in_byte,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [7:0]                      out_byte,
	output logic [1:0]                      status,
	output logic                            last,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [fltd_pkg::END_CODE_W-1:0] end_code
);
	import fltd_pkg::*;

	logic [END_CODE_W-1:0] end_code_q;
	logic                  q_valid;
	cmd_t                  q_cmd;
	logic                  q_pop;
	logic                  run;
	logic                  res_ok;
	res_ctl_t              res_ctl;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			end_code_q <= END_CODE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			end_code_q <= end_code;
		end
	end

	fltd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.entry_index  (entry_index),
		.entry_byte0  (entry_byte0),
		.entry_byte1  (entry_byte1),
		.entry_byte2  (entry_byte2),
		.entry_byte3  (entry_byte3),
		.entry_length (entry_length),
		.in_byte      (in_byte),
		.run          (run),
		.q_valid      (q_valid),
		.q_cmd        (q_cmd),
		.q_pop        (q_pop)
	);

	fltd_back #(
		.CODE_BITS    (CODE_BITS),
		.SYMBOL_BYTES (SYMBOL_BYTES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.end_code (end_code_q),
		.q_valid  (q_valid),
		.q_cmd    (q_cmd),
		.q_pop    (q_pop),
		.run      (run),
		.res_ok   (res_ok),
		.res_ctl  (res_ctl)
	);

	fltd_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_ctl   (res_ctl),
		.res_ok    (res_ok),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.status    (status),
		.last      (last)
	);

endmodule
